// ----- rtl/mwcrc_pkg.sv -----
// Shared types, mode codes and CRC step functions for the multi-width CRC engine.
// Used by mwcrc_cfg, mwcrc_core and multi_width_crc_engine; depends on nothing.
package mwcrc_pkg;

  typedef enum logic [2:0] {
    MODE_CRC4     = 3'd0,
    MODE_CRC7     = 3'd1,
    MODE_CRC8_MSB = 3'd2,
    MODE_CRC8_REF = 3'd3,
    MODE_CRC16_LSB = 3'd4,
    MODE_CRC16_MSB = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    REG_CRC_MODE    = 2'd0,
    REG_GENERATOR   = 2'd1,
    REG_START_VALUE = 2'd2
  } reg_index_t;

  localparam logic [2:0]  RESET_MODE      = MODE_CRC8_MSB;
  localparam logic [15:0] RESET_GENERATOR = 16'h0007;
  localparam logic [15:0] RESET_START     = 16'h0000;

  typedef struct packed {
    logic [2:0]  crc_mode;
    logic [15:0] generator;
    logic [15:0] start_value;
  } cfg_t;

  function automatic mode_t eff_mode(logic [2:0] code);
    mode_t m;
    case (code)
      MODE_CRC4:      m = MODE_CRC4;
      MODE_CRC7:      m = MODE_CRC7;
      MODE_CRC8_REF:  m = MODE_CRC8_REF;
      MODE_CRC16_LSB: m = MODE_CRC16_LSB;
      MODE_CRC16_MSB: m = MODE_CRC16_MSB;
      default:        m = MODE_CRC8_MSB;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] rev8(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  function automatic logic [15:0] shaped_init(mode_t m, logic [15:0] start);
    logic [15:0] r;
    case (m)
      MODE_CRC4:      r = {8'h00, start[3:0], 4'h0};
      MODE_CRC7:      r = {8'h00, start[6:0], 1'b0};
      MODE_CRC8_REF:  r = {8'h00, rev8(start[7:0])};
      MODE_CRC16_LSB: r = start;
      MODE_CRC16_MSB: r = start;
      default:        r = {8'h00, start[7:0]};
    endcase
    return r;
  endfunction

  function automatic logic [15:0] crc_absorb(mode_t m, logic [15:0] rem, logic [7:0] b,
                                             logic [15:0] gen);
    logic [15:0] r16;
    logic [7:0]  r8;
    logic [7:0]  p8;
    logic [15:0] res;
    r16 = '0;
    r8  = '0;
    p8  = '0;
    case (m)
      MODE_CRC16_LSB: begin
        r16 = rem ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
          r16 = r16[0] ? ((r16 >> 1) ^ gen) : (r16 >> 1);
        end
        res = r16;
      end
      MODE_CRC16_MSB: begin
        r16 = rem ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
          r16 = r16[15] ? ({r16[14:0], 1'b0} ^ gen) : {r16[14:0], 1'b0};
        end
        res = r16;
      end
      MODE_CRC8_REF: begin
        r8 = rem[7:0] ^ b;
        p8 = rev8(gen[7:0]);
        for (int i = 0; i < 8; i++) begin
          r8 = r8[0] ? ((r8 >> 1) ^ p8) : (r8 >> 1);
        end
        res = {8'h00, r8};
      end
      default: begin
        case (m)
          MODE_CRC4: p8 = {gen[3:0], 4'h0};
          MODE_CRC7: p8 = {gen[6:0], 1'b0};
          default:   p8 = gen[7:0];
        endcase
        r8 = rem[7:0] ^ b;
        for (int i = 0; i < 8; i++) begin
          r8 = r8[7] ? ({r8[6:0], 1'b0} ^ p8) : {r8[6:0], 1'b0};
        end
        res = {8'h00, r8};
      end
    endcase
    return res;
  endfunction

  function automatic logic [15:0] final_value(mode_t m, logic [15:0] rem);
    logic [15:0] r;
    case (m)
      MODE_CRC4:      r = {12'h000, rem[7:4]};
      MODE_CRC7:      r = {9'h000, rem[7:1]};
      MODE_CRC16_LSB: r = rem;
      MODE_CRC16_MSB: r = rem;
      default:        r = {8'h00, rem[7:0]};
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mwcrc_cfg.sv -----
// Configuration register file: mode, generator polynomial and start value.
// Depends on mwcrc_pkg.
module mwcrc_cfg import mwcrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crc_mode    <= RESET_MODE;
      cfg.generator   <= RESET_GENERATOR;
      cfg.start_value <= RESET_START;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_CRC_MODE:    cfg.crc_mode    <= wr_data[2:0];
        REG_GENERATOR:   cfg.generator   <= wr_data;
        REG_START_VALUE: cfg.start_value <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/mwcrc_core.sv -----
// Running remainder and message state; absorbs one byte per accepted word.
// Depends on mwcrc_pkg.
module mwcrc_core import mwcrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic [15:0] crc_final
);

  logic [15:0] remainder;
  logic        in_message;
  logic [15:0] remainder_next;
  mode_t       mode;

  assign mode           = eff_mode(cfg.crc_mode);
  assign remainder_next = crc_absorb(mode,
                                     in_message ? remainder : shaped_init(mode, cfg.start_value),
                                     data_byte, cfg.generator);
  assign crc_final      = final_value(mode, remainder_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder  <= '0;
      in_message <= 1'b0;
    end else if (step) begin
      remainder  <= remainder_next;
      in_message <= ~last_byte;
    end
  end

endmodule

// ----- rtl/multi_width_crc_engine.sv -----
// Top level of the multi-width CRC engine: config registers, CRC core, result register.
// Depends on mwcrc_pkg, mwcrc_cfg and mwcrc_core.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------
//   byte     | in        | byte_valid / byte_stall   | data_byte, last_byte
//   crc      | out       | crc_valid / crc_stall     | crc_value
//   cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One byte per cycle while byte_stall is low; the CRC of a message is valid the cycle
// after its last byte. The eight bit steps of a byte form one XOR network between the
// remainder register and itself; the result register sits after it.
// Reset loads crc8 msb-first mode, generator 0x07, start value 0, and clears
// crc_valid. The byte side stalls only while a result waits under crc_stall.
module multi_width_crc_engine import mwcrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        crc_valid,
  input  logic        crc_stall,
  output logic [15:0] crc_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  logic        step;
  logic [15:0] crc_final;

  assign cfg_ready  = 1'b1;
  assign byte_stall = crc_valid & crc_stall;
  assign step       = byte_valid & ~byte_stall;

  mwcrc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mwcrc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .crc_final (crc_final)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_valid <= 1'b0;
    end else if (step && last_byte) begin
      crc_valid <= 1'b1;
    end else if (!crc_stall) begin
      crc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last_byte) begin
      crc_value <= crc_final;
    end
  end

endmodule
